// File: design/lesf_pkg.sv
// Shared types and constants for the largest empty square finder.
// No dependencies; imported by the result queue and the top level.
package lesf_pkg;

    // Score and output field widths
    localparam int SCORE_W = 11;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 10;

    // Configuration register indexes
    localparam logic [1:0] CFG_OBSTACLE  = 2'd0;
    localparam logic [1:0] CFG_ROW_WIDTH = 2'd1;
    localparam logic [1:0] CFG_ROW_COUNT = 2'd2;

    // Depth of the result queue in front of the master port
    localparam int RES_DEPTH   = 3;
    localparam int RES_CNT_W   = 2;

    // One result beat
    typedef struct packed {
        logic [ROW_W-1:0]   end_row;
        logic [COL_W-1:0]   end_column;
        logic [SCORE_W-1:0] square_size;
    } t_result;

endpackage

// File: design/largest_empty_square_finder.sv
// Largest empty square finder: streaming maximal-square scan with a line store.
// Depends on lesf_pkg and lesf_result_queue.
//
// Grid cells enter one per beat on s_axis in row-major order, one cell per clock
// when the master side keeps up. Each cell is handled in order: the accept
// cycle issues the line store read for its column, the next cycle forms the score
// from the upper, left and upper-left scores and writes it back. The line store
// has one read and one write port; when two consecutive cells use the same column
// (one-column grids) the fresh score is forwarded around the store. On the last
// cell of the configured grid a result beat (size, bottom-right column and row)
// is queued; up to three results can wait on m_axis before s_axis stalls. The line
// store needs no clearing: every entry whose value a score uses was written earlier
// in the same grid (first-row reads are ignored).
// Configuration writes are taken at any time and should be made while idle.
module largest_empty_square_finder
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // cell stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] cell_char
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [10:0] square_size, [20:11] end_column,
                                        // [30:21] end_row, [31] zero
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // Configuration, held as last column / last row index
    logic [7:0]    r_obstacle;
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;

    // Scan position at the input
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // Score stage
    logic               r_s1_valid;
    logic [CW-1:0]      r_s1_col;
    logic [RW-1:0]      r_s1_row;
    logic               r_s1_obst;
    logic               r_s1_edge;
    logic               r_s1_row_end;
    logic               r_s1_grid_end;
    logic               r_s1_fwd;
    logic [SCORE_W-1:0] r_rd;
    logic [SCORE_W-1:0] r_prev_score;
    logic [SCORE_W-1:0] r_left;
    logic [SCORE_W-1:0] r_diag;
    logic [SCORE_W-1:0] r_best;
    logic [CW-1:0]      r_best_col;
    logic [RW-1:0]      r_best_row;

    logic [SCORE_W-1:0] mem [MAX_COLS];

    logic               w_accept;
    logic               w_row_end;
    logic               w_grid_end;
    logic [SCORE_W-1:0] w_up;
    logic [SCORE_W-1:0] w_min;
    logic [SCORE_W:0]   w_sum;
    logic [SCORE_W-1:0] w_score;
    logic               w_better;
    logic               w_push;
    t_result            w_res;
    t_result            w_head;
    logic [RES_CNT_W-1:0] w_q_count;
    logic [RES_CNT_W:0] w_occ;

    logic [CW-1:0]      n_col;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      n_last_col;
    logic [RW-1:0]      n_last_row;

    // Configuration writes: clamp dimensions to 1..MAX and keep them minus one
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_last_col = '0;
            n_last_row = '0;
        end else begin
            n_last_col = (32'(i_cfg_data) > MAX_COLS) ? CW'(MAX_COLS - 1)
                                                      : CW'(i_cfg_data - 11'd1);
            n_last_row = (32'(i_cfg_data) > MAX_ROWS) ? RW'(MAX_ROWS - 1)
                                                      : RW'(i_cfg_data - 11'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle <= 8'd111;
            r_last_col <= '0;
            r_last_row <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_OBSTACLE:  r_obstacle <= i_cfg_data[7:0];
                CFG_ROW_WIDTH: r_last_col <= n_last_col;
                CFG_ROW_COUNT: r_last_row <= n_last_row;
                default: ;
            endcase
        end
    end

    // Input side: accept when the result path has room for a pending result
    assign w_occ         = {1'b0, w_q_count} + (RES_CNT_W+1)'(r_s1_valid && r_s1_grid_end);
    assign s_axis_tready = (w_occ < (RES_CNT_W+1)'(RES_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_row_end  = (r_col >= r_last_col);
    assign w_grid_end = w_row_end && (r_row >= r_last_row);

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (w_grid_end) begin
            n_col = '0;
            n_row = '0;
        end else if (w_row_end) begin
            n_col = '0;
            n_row = r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Cell attributes into the score stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_obst     <= (s_axis_tdata == r_obstacle);
            r_s1_edge     <= (r_row == '0) || (r_col == '0);
            r_s1_row_end  <= w_row_end;
            r_s1_grid_end <= w_grid_end;
            // the store write of the cell ahead lands on this same edge
            r_s1_fwd      <= r_s1_valid && (r_s1_col == r_col);
        end
    end

    // Line store: read on accept, write back from the score stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= mem[r_col];
        end
        if (r_s1_valid) begin
            mem[r_s1_col] <= w_score;
        end
    end

    // Score: 0 on obstacle, 1 on an edge, else 1 + min(up, left, diag), saturating
    assign w_up  = r_s1_fwd ? r_prev_score : r_rd;
    always_comb begin
        w_min = w_up;
        if (r_left < w_min) begin
            w_min = r_left;
        end
        if (r_diag < w_min) begin
            w_min = r_diag;
        end
        w_sum = {1'b0, w_min} + (SCORE_W+1)'(1);
        if (r_s1_obst) begin
            w_score = '0;
        end else if (r_s1_edge) begin
            w_score = SCORE_W'(1);
        end else if (w_sum[SCORE_W]) begin
            w_score = '1;
        end else begin
            w_score = w_sum[SCORE_W-1:0];
        end
    end

    assign w_better = (w_score > r_best);

    // Neighbor scores and running best
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_diag       <= '0;
            r_best       <= '0;
            r_best_col   <= '0;
            r_best_row   <= '0;
            r_prev_score <= '0;
        end else if (r_s1_valid) begin
            r_prev_score <= w_score;
            if (r_s1_grid_end) begin
                r_left     <= '0;
                r_diag     <= '0;
                r_best     <= '0;
                r_best_col <= '0;
                r_best_row <= '0;
            end else begin
                if (r_s1_row_end) begin
                    r_left <= '0;
                    r_diag <= '0;
                end else begin
                    r_left <= w_score;
                    r_diag <= w_up;
                end
                if (w_better) begin
                    r_best     <= w_score;
                    r_best_col <= r_s1_col;
                    r_best_row <= r_s1_row;
                end
            end
        end
    end

    // Result of the grid's last cell, including that cell itself
    assign w_push = r_s1_valid && r_s1_grid_end;
    always_comb begin
        w_res.square_size = w_better ? w_score : r_best;
        w_res.end_column  = COL_W'(w_better ? r_s1_col : r_best_col);
        w_res.end_row     = ROW_W'(w_better ? r_s1_row : r_best_row);
    end

    lesf_result_queue u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_count (w_q_count),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_head)
    );

    assign m_axis_tdata = {1'b0, w_head};

    // The score stage holds exactly the beat accepted on the previous edge
    a_s1_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> $past(w_accept))
        else $error("score stage valid without an accepted beat");

    // Forwarding is only needed when a cell repeats the column of the one before
    a_fwd_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_s1_valid && (r_s1_col != r_col)) |=> !r_s1_fwd)
        else $error("forward taken for a different column");

endmodule

// File: design/lesf_result_queue.sv
// Small shift queue holding finished results until the master side takes them.
// Depends on lesf_pkg for the result type and queue depth.
module lesf_result_queue
    import lesf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_result              i_data,
    output logic [RES_CNT_W-1:0] o_count,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_data
);

    t_result              r_q [RES_DEPTH];
    logic [RES_CNT_W-1:0] r_count;
    logic [RES_CNT_W-1:0] n_count;
    logic                 w_pop;
    logic [RES_CNT_W-1:0] w_wr_idx;

    assign w_pop    = (r_count != '0) && i_ready;
    assign w_wr_idx = r_count - RES_CNT_W'(w_pop);
    assign n_count  = r_count + RES_CNT_W'(i_push) - RES_CNT_W'(w_pop);

    // Count of held beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Entry 0 is the head; shift on pop, fill at the first free slot
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RES_DEPTH; i++) begin
            if (i_push && (w_wr_idx == RES_CNT_W'(i))) begin
                r_q[i] <= i_data;
            end else if (w_pop && (i < RES_DEPTH - 1)) begin
                r_q[i] <= r_q[(i < RES_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_q[0];

    // Upstream must hold off when the queue is full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !w_pop && (r_count == RES_CNT_W'(RES_DEPTH))))
        else $error("result queue overflow");

    // A queued beat that is not taken stays at the head
    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result head changed while stalled");

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for largest_empty_square_finder.
// Depends on lesf_pkg and the design sources; holds its own maximal-square scan
// predictor and drives random grids through the cell and result streams.
module tb;
    import lesf_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int SCORE_CAP    = 2047;
    localparam int ITEM_TARGET  = 600;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_200_000;

    // DUT ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = CFG_OBSTACLE;
    logic [10:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] cell_char
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [10:0] square_size, [20:11] end_column,
                                       // [30:21] end_row, [31] zero

    // Stimulus and expectation stores
    logic [7:0] cell_q[$];
    t_result    square_q[$];
    int         err_count  = 0;
    int         cycle_cnt  = 0;
    int         cell_gap   = 0;
    int         sink_gap   = 0;
    int         hold_left  = 0;
    bit         hold_arm   = 1'b0;
    bit         hold_done  = 1'b0;
    bit         no_gaps    = 1'b0;

    // Configuration mirror (reset values)
    logic [7:0]  blk_char = 8'd111;
    logic [10:0] cols_cfg = 11'd1;
    logic [10:0] rows_cfg = 11'd1;

    // Scan state mirror
    logic [SCORE_W-1:0] line_scores [MAX_COLS] = '{default: '0};
    logic [SCORE_W-1:0] left_sc  = '0;
    logic [SCORE_W-1:0] diag_sc  = '0;
    logic [SCORE_W-1:0] best_sz  = '0;
    logic [COL_W-1:0]   scan_col = '0;
    logic [COL_W-1:0]   best_c   = '0;
    logic [ROW_W-1:0]   scan_row = '0;
    logic [ROW_W-1:0]   best_r   = '0;

    largest_empty_square_finder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Zero is taken as one, oversize saturates
    function automatic int dim_limit(input logic [10:0] v, input int top);
        if (v == 0) return 1;
        if (int'(v) > top) return top;
        return int'(v);
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(input bit busy);
        int r;
        r = $urandom_range(0, 99);
        if (busy || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Cell character: obstacle with the given odds, else a near miss or random
    function automatic logic [7:0] pick_char(input int blk_pct);
        logic [7:0] c;
        if ($urandom_range(0, 99) < blk_pct) return blk_char;
        if ($urandom_range(0, 1)) begin
            c = blk_char ^ (8'd1 << $urandom_range(0, 7));
        end else begin
            c = 8'($urandom_range(0, 255));
            if (c == blk_char) c = ~blk_char;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    // Maximal-square step for one accepted cell; queues the result on grid end
    task automatic score_cell(input logic [7:0] ch);
        int      width;
        int      height;
        int      col;
        int      up_sc;
        int      sc;
        t_result res;
        width  = dim_limit(cols_cfg, MAX_COLS);
        height = dim_limit(rows_cfg, MAX_ROWS);
        col    = (int'(scan_col) >= MAX_COLS) ? MAX_COLS - 1 : int'(scan_col);
        up_sc  = int'(line_scores[col]);
        if (ch == blk_char) begin
            sc = 0;
        end else if (scan_row == 0 || col == 0) begin
            sc = 1;
        end else begin
            sc = up_sc;
            if (int'(left_sc) < sc) sc = int'(left_sc);
            if (int'(diag_sc) < sc) sc = int'(diag_sc);
            sc = sc + 1;
            if (sc > SCORE_CAP) sc = SCORE_CAP;
        end
        line_scores[col] = SCORE_W'(sc);
        diag_sc = SCORE_W'(up_sc);
        left_sc = SCORE_W'(sc);
        // strict compare: first square found keeps a tie
        if (sc > int'(best_sz)) begin
            best_sz = SCORE_W'(sc);
            best_c  = COL_W'(col);
            best_r  = scan_row;
        end
        if (col + 1 >= width) begin
            if (int'(scan_row) + 1 >= height) begin
                res.square_size = best_sz;
                res.end_column  = best_c;
                res.end_row     = best_r;
                square_q.push_back(res);
                left_sc  = '0;
                diag_sc  = '0;
                scan_col = '0;
                scan_row = '0;
                best_sz  = '0;
                best_c   = '0;
                best_r   = '0;
            end else begin
                scan_col = '0;
                scan_row = scan_row + 1'b1;
                left_sc  = '0;
                diag_sc  = '0;
            end
        end else begin
            scan_col = COL_W'(col + 1);
        end
    endtask

    // Compare one result beat with the oldest expectation
    task automatic check_square(input logic [31:0] beat);
        t_result got;
        t_result want;
        got = t_result'(beat[30:0]);
        if (square_q.size() == 0) begin
            report_mismatch($sformatf("result with none expected: data=%h", beat));
        end else begin
            want = square_q.pop_front();
            if (got.square_size !== want.square_size)
                report_mismatch($sformatf("square_size got %0d want %0d",
                                          got.square_size, want.square_size));
            if (got.end_column !== want.end_column)
                report_mismatch($sformatf("end_column got %0d want %0d",
                                          got.end_column, want.end_column));
            if (got.end_row !== want.end_row)
                report_mismatch($sformatf("end_row got %0d want %0d",
                                          got.end_row, want.end_row));
            if (beat[31] !== 1'b0)
                report_mismatch("pad bit of result beat not zero");
        end
    endtask

    // Cell driver: scores each accepted beat, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) score_cell(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (cell_gap > 0) begin
                    cell_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (cell_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cell_q.pop_front();
                    cell_gap = pick_gap(no_gaps);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_square(m_axis_tdata);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_gap = pick_gap(no_gaps);
            end
        end
    end

    // Long receiver hold-off, started once on request and counted down here
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TIMEOUT: cycle limit reached, %0d results outstanding",
                     square_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Wait until every cell is in and every result is out, then let the pipe drain
    task automatic settle();
        do @(posedge i_clk);
        while (cell_q.size() != 0 || s_axis_tvalid || square_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; mirror follows on acceptance
    task automatic cfg_write(input logic [1:0] idx, input logic [10:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_OBSTACLE:  blk_char = val[7:0];
            CFG_ROW_WIDTH: cols_cfg = val;
            CFG_ROW_COUNT: rows_cfg = val;
            default: ;
        endcase
    endtask

    // Program any subset of the registers; call only while idle
    task automatic program_grid(input bit wr_o, input bit wr_w, input bit wr_c,
                                input logic [7:0] obst, input logic [10:0] w,
                                input logic [10:0] c);
        if (wr_o) cfg_write(CFG_OBSTACLE, {3'($urandom), obst});
        if (wr_w) cfg_write(CFG_ROW_WIDTH, w);
        if (wr_c) cfg_write(CFG_ROW_COUNT, c);
        if (wr_o || wr_w || wr_c) i_cfg_valid <= 1'b0;
    endtask

    // Queue one whole grid for the current configuration
    task automatic push_grid(input int blk_pct, inout int n_cells);
        int total;
        total = dim_limit(cols_cfg, MAX_COLS) * dim_limit(rows_cfg, MAX_ROWS);
        for (int k = 0; k < total; k++) cell_q.push_back(pick_char(blk_pct));
        n_cells += total;
    endtask

    // Random dimension: mostly small, some zero, a few medium
    function automatic logic [10:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 11'd0;
        if (r < 10) return 11'($urandom_range(13, 40));
        return 11'($urandom_range(1, 12));
    endfunction

    initial begin
        int n_rand;
        int n_extra;
        int n_grids;
        int pct;
        int r;
        logic [7:0] obst;
        n_rand  = 0;
        n_extra = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: 1x1 grids, obstacle 'o'; blocked cell gives all zeros
        cell_q.push_back(8'd111);
        cell_q.push_back(8'd110);
        cell_q.push_back(8'h00);
        cell_q.push_back(8'hFF);
        settle();

        // Zero width and count behave as one
        program_grid(1, 1, 1, 8'h00, 11'd0, 11'd0);
        cell_q.push_back(8'h00);
        cell_q.push_back(8'hFF);
        cell_q.push_back(8'h80);
        settle();

        // 3x3: fully open grid, then a grid with two blocked corners and a tie
        program_grid(1, 1, 1, 8'hFF, 11'd3, 11'd3);
        for (int k = 0; k < 9; k++) cell_q.push_back(8'h00);
        cell_q.push_back(8'hFF);
        cell_q.push_back(8'h01);
        cell_q.push_back(8'h02);
        cell_q.push_back(8'h04);
        cell_q.push_back(8'h08);
        cell_q.push_back(8'h10);
        cell_q.push_back(8'h20);
        cell_q.push_back(8'h40);
        cell_q.push_back(8'hFF);
        settle();

        // Saturated width, one row: reaches the last column
        program_grid(1, 1, 1, 8'($urandom), 11'd2047, 11'd1);
        push_grid(3, n_extra);
        settle();

        // Back-pressure: one-cell grids while the receiver holds off
        program_grid(1, 1, 1, 8'($urandom), 11'd1, 11'd1);
        no_gaps = 1'b1;
        @(negedge i_clk);
        hold_arm = 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < 40; k++) cell_q.push_back(pick_char(40));
        settle();
        no_gaps = 1'b0;

        // Random grids, a few per configuration
        while (n_rand < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            obst = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
            program_grid($urandom_range(0, 9) < 6, $urandom_range(0, 9) < 7,
                         $urandom_range(0, 9) < 7, obst, pick_dim(), pick_dim());
            no_gaps = ($urandom_range(0, 3) == 0);
            n_grids = $urandom_range(1, 4);
            for (int g = 0; g < n_grids; g++) begin
                r = $urandom_range(0, 19);
                pct = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(5, 50);
                push_grid(pct, n_rand);
            end
            settle();
        end

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
